### rtl/bpp_pkg.sv
package bpp_pkg;

    localparam int COORD_W = 24;
    localparam int PARAM_W = 32;
    localparam int ITER_W  = 8;
    localparam int TOL_W   = 47;
    localparam int PF      = 28;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_TOL   = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;

    // scratch memory slots
    localparam logic [4:0] SL_T      = 5'd0;
    localparam logic [4:0] SL_X_BASE = 5'd1;
    localparam logic [4:0] SL_Y_BASE = 5'd9;
    localparam logic [4:0] SL_P      = 5'd17;
    localparam logic [4:0] SL_V      = 5'd18;
    localparam logic [4:0] SL_W      = 5'd19;
    localparam logic [4:0] SL_FX     = 5'd20;
    localparam logic [4:0] SL_FPX    = 5'd21;
    localparam logic [4:0] SL_FPPX   = 5'd22;
    localparam logic [4:0] SL_DX     = 5'd23;
    localparam logic [4:0] SL_FY     = 5'd24;
    localparam logic [4:0] SL_FPY    = 5'd25;
    localparam logic [4:0] SL_FPPY   = 5'd26;
    localparam logic [4:0] SL_DY     = 5'd27;
    localparam logic [4:0] SL_G      = 5'd28;
    localparam logic [4:0] SL_H      = 5'd29;
    localparam int         SLOTS     = 30;

    // per-axis coefficient offsets
    localparam logic [2:0] CO_S0  = 3'd0;
    localparam logic [2:0] CO_S1  = 3'd1;
    localparam logic [2:0] CO_S2  = 3'd2;
    localparam logic [2:0] CO_S2D = 3'd3;
    localparam logic [2:0] CO_A3  = 3'd4;
    localparam logic [2:0] CO_A3T = 3'd5;
    localparam logic [2:0] CO_A3S = 3'd6;
    localparam logic [2:0] CO_QN  = 3'd7;

    localparam logic [5:0] UOP_AXIS = 6'd13;
    localparam logic [5:0] UOP_LAST = 6'd35;

    typedef enum logic {OP_ADD, OP_MUL} t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] dst;
        logic [4:0] a;
        logic [4:0] b;
        logic       sh;
    } t_uop;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [64:0] lim;
        lim = {1'b0, SAT_MAX};
        s = {a[63], a} + {b[63], b};
        if (s > lim) return SAT_MAX;
        if (s < -lim) return -SAT_MAX;
        return s[63:0];
    endfunction

    function automatic t_uop mk(input t_op op, input logic [4:0] dst,
                                input logic [4:0] a, input logic [4:0] b, input logic sh);
        t_uop u;
        u.op = op;
        u.dst = dst;
        u.a = a;
        u.b = b;
        u.sh = sh;
        return u;
    endfunction

    // newton iteration program
    function automatic t_uop uop_at(input logic [5:0] pc);
        t_uop u;
        logic [4:0] cb;
        logic [4:0] rb;
        logic [5:0] k;
        u = mk(OP_ADD, SL_P, SL_P, SL_P, 1'b0);
        if (pc < UOP_AXIS) begin
            k = pc;
            cb = SL_X_BASE;
            rb = SL_FX;
        end else begin
            k = pc - UOP_AXIS;
            cb = SL_Y_BASE;
            rb = SL_FY;
        end
        if (pc < 2 * UOP_AXIS) begin
            case (k)
                6'd0:  u = mk(OP_MUL, SL_P, cb + 5'(CO_A3), SL_T, 1'b0);
                6'd1:  u = mk(OP_ADD, SL_P, cb + 5'(CO_S2), SL_P, 1'b0);
                6'd2:  u = mk(OP_MUL, SL_P, SL_P, SL_T, 1'b1);
                6'd3:  u = mk(OP_ADD, SL_P, cb + 5'(CO_S1), SL_P, 1'b0);
                6'd4:  u = mk(OP_MUL, SL_P, SL_P, SL_T, 1'b1);
                6'd5:  u = mk(OP_ADD, rb, cb + 5'(CO_S0), SL_P, 1'b0);
                6'd6:  u = mk(OP_MUL, SL_P, cb + 5'(CO_A3T), SL_T, 1'b0);
                6'd7:  u = mk(OP_ADD, SL_P, cb + 5'(CO_S2D), SL_P, 1'b0);
                6'd8:  u = mk(OP_MUL, SL_P, SL_P, SL_T, 1'b1);
                6'd9:  u = mk(OP_ADD, rb + 5'd1, cb + 5'(CO_S1), SL_P, 1'b0);
                6'd10: u = mk(OP_MUL, SL_P, cb + 5'(CO_A3S), SL_T, 1'b0);
                6'd11: u = mk(OP_ADD, rb + 5'd2, cb + 5'(CO_S2D), SL_P, 1'b0);
                6'd12: u = mk(OP_ADD, rb + 5'd3, rb, cb + 5'(CO_QN), 1'b0);
                default: u = mk(OP_ADD, SL_P, SL_P, SL_P, 1'b0);
            endcase
        end else begin
            case (pc - 2 * UOP_AXIS)
                6'd0: u = mk(OP_MUL, SL_V, SL_DX, SL_FPX, 1'b1);
                6'd1: u = mk(OP_MUL, SL_W, SL_DY, SL_FPY, 1'b1);
                6'd2: u = mk(OP_ADD, SL_G, SL_V, SL_W, 1'b0);
                6'd3: u = mk(OP_MUL, SL_V, SL_DX, SL_FPPX, 1'b1);
                6'd4: u = mk(OP_MUL, SL_W, SL_DY, SL_FPPY, 1'b1);
                6'd5: u = mk(OP_ADD, SL_V, SL_V, SL_W, 1'b0);
                6'd6: u = mk(OP_MUL, SL_W, SL_FPX, SL_FPX, 1'b1);
                6'd7: u = mk(OP_MUL, SL_P, SL_FPY, SL_FPY, 1'b1);
                6'd8: u = mk(OP_ADD, SL_W, SL_W, SL_P, 1'b0);
                6'd9: u = mk(OP_ADD, SL_H, SL_V, SL_W, 1'b0);
                default: u = mk(OP_ADD, SL_P, SL_P, SL_P, 1'b0);
            endcase
        end
        return u;
    endfunction

    // power-form coefficient, prescaled where it is only ever added
    function automatic logic signed [63:0] coef(input logic [2:0] j,
                                                input logic signed [63:0] s,
                                                input logic signed [63:0] c1,
                                                input logic signed [63:0] c2,
                                                input logic signed [63:0] e,
                                                input logic signed [63:0] q);
        logic signed [63:0] a1;
        logic signed [63:0] a2;
        logic signed [63:0] a3;
        logic signed [63:0] r;
        a1 = 64'sd3 * (c1 - s);
        a2 = 64'sd3 * (c2 - 64'sd2 * c1 + s);
        a3 = e - 64'sd3 * c2 + 64'sd3 * c1 - s;
        case (j)
            CO_S0:   r = s <<< PF;
            CO_S1:   r = a1 <<< PF;
            CO_S2:   r = a2 <<< PF;
            CO_S2D:  r = (64'sd2 * a2) <<< PF;
            CO_A3:   r = a3;
            CO_A3T:  r = 64'sd3 * a3;
            CO_A3S:  r = 64'sd6 * a3;
            CO_QN:   r = (-q) <<< PF;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/bezier_point_projection_core.sv
// cubic bezier point projection by newton iteration, fixed point
// input channel: i_valid / o_stall carry the four curve points, the query point
//   and the start parameter; a transaction is taken when i_valid is high and
//   o_stall is low. o_stall is low only while the core is idle
// output channel: o_valid / i_stall carry projected_param, iterations_used and
//   converged; the result is held in an output register until taken, and a new
//   input transaction may be taken while it waits
// config channel: i_cfg_valid / o_cfg_ready (always ready); index 0 is the
//   gradient tolerance, index 1 the iteration limit, other indexes are ignored
// operation: the coefficient scratch memory is loaded first, then each iteration
//   runs a 36-op program (18 multiplies on the shared multiplier, 18 adds)
//   followed by a gradient step, or by a newton step through the bit-serial
//   divider when the curvature term is positive
// one transaction is in work at a time; the next one can be taken in the cycle
//   after the result is registered
// reset: synchronous active low; tolerance returns to 1, limit to 20, no
//   result pending. if the receiver stalls, the finished result waits in the
//   output register and the next finished result waits until it is taken
module bezier_point_projection_core
    import bpp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic signed [COORD_W-1:0] i_first_ctrl_x,
    input  logic signed [COORD_W-1:0] i_first_ctrl_y,
    input  logic signed [COORD_W-1:0] i_second_ctrl_x,
    input  logic signed [COORD_W-1:0] i_second_ctrl_y,
    input  logic signed [COORD_W-1:0] i_end_x,
    input  logic signed [COORD_W-1:0] i_end_y,
    input  logic signed [COORD_W-1:0] i_query_x,
    input  logic signed [COORD_W-1:0] i_query_y,
    input  logic signed [PARAM_W-1:0] i_initial_param,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [PARAM_W-1:0] o_projected_param,
    output logic [ITER_W-1:0]         o_iterations_used,
    output logic                      o_converged,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [TOL_W-1:0]          i_cfg_data
);

    localparam logic [4:0] LOAD_LAST = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_CHECK, ST_RD, ST_EX, ST_MW, ST_STEP, ST_DW, ST_UPD, ST_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [TOL_W-1:0]  r_tol;
    logic [ITER_W-1:0] r_limit;

    // captured transaction
    logic signed [COORD_W-1:0] r_pt [10];
    logic signed [PARAM_W-1:0] r_t;

    // iteration control
    logic [4:0]        r_ld;
    logic [5:0]        r_pc;
    logic [ITER_W-1:0] r_cnt;
    logic              r_conv;
    logic signed [63:0] r_g;
    logic signed [63:0] r_h;
    logic signed [63:0] r_delta;

    // output register
    logic                      r_ov;
    logic signed [PARAM_W-1:0] r_o_param;
    logic [ITER_W-1:0]         r_o_iter;
    logic                      r_o_conv;

    // scratch memory, one write and two registered reads
    logic signed [63:0] r_mem [SLOTS];
    logic signed [63:0] r_rda;
    logic signed [63:0] r_rdb;

    t_uop               cur;
    logic               we;
    logic [4:0]         wa;
    logic signed [63:0] wd;
    logic signed [63:0] ld_val;
    logic signed [63:0] add_res;
    logic               mul_start;
    logic               mul_done;
    logic signed [63:0] mul_p;
    logic               div_start;
    logic               div_done;
    logic [63:0]        div_q;
    logic [63:0]        g_mag;
    logic               h_pos;
    logic signed [64:0] t_sum;
    logic signed [PARAM_W-1:0] t_new;
    logic               in_take;
    logic               axis;
    logic [2:0]         cj;

    assign cur     = uop_at(r_pc);
    assign add_res = sat_add(r_rda, r_rdb);
    assign g_mag   = r_g[63] ? 64'(-r_g) : r_g;
    assign h_pos   = !r_h[63] && (r_h != '0);
    assign in_take = i_valid && (r_state == ST_IDLE);

    // coefficient load: slot 0 is t, then eight per axis
    always_comb begin
        axis = (r_ld - 5'd1) >= 5'd8;
        cj   = 3'(r_ld - 5'd1);
        if (r_ld == SL_T) begin
            ld_val = {{(64-PARAM_W){r_t[PARAM_W-1]}}, r_t};
        end else if (!axis) begin
            ld_val = coef(cj, 64'(r_pt[0]), 64'(r_pt[2]), 64'(r_pt[4]),
                          64'(r_pt[6]), 64'(r_pt[8]));
        end else begin
            ld_val = coef(cj, 64'(r_pt[1]), 64'(r_pt[3]), 64'(r_pt[5]),
                          64'(r_pt[7]), 64'(r_pt[9]));
        end
    end

    // parameter update, clamp to the parameter range
    always_comb begin
        t_sum = {{(65-PARAM_W){r_t[PARAM_W-1]}}, r_t} + {r_delta[63], r_delta};
        if (t_sum > 65'sd2147483647) t_new = {1'b0, {(PARAM_W-1){1'b1}}};
        else if (t_sum < -65'sd2147483648) t_new = {1'b1, {(PARAM_W-1){1'b0}}};
        else t_new = t_sum[PARAM_W-1:0];
    end

    // write port select
    always_comb begin
        we = 1'b0;
        wa = cur.dst;
        wd = add_res;
        case (r_state)
            ST_LOAD: begin
                we = 1'b1;
                wa = r_ld;
                wd = ld_val;
            end
            ST_EX: begin
                we = (cur.op == OP_ADD);
            end
            ST_MW: begin
                we = mul_done;
                wd = mul_p;
            end
            ST_UPD: begin
                we = 1'b1;
                wa = SL_T;
                wd = {{(64-PARAM_W){t_new[PARAM_W-1]}}, t_new};
            end
            default: we = 1'b0;
        endcase
    end

    assign mul_start = (r_state == ST_EX) && (cur.op == OP_MUL);
    assign div_start = (r_state == ST_STEP) && h_pos;

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rda <= r_mem[cur.a];
        r_rdb <= r_mem[cur.b];
    end

    bpp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_rda),
        .i_b     (r_rdb),
        .i_shift (cur.sh),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    bpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (g_mag),
        .i_den   (r_h),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tol   <= TOL_W'(1);
            r_limit <= ITER_W'(20);
            r_ov    <= 1'b0;
            r_ld    <= '0;
            r_pc    <= '0;
            r_cnt   <= '0;
            r_conv  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TOL:   r_tol   <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data[ITER_W-1:0];
                    default:   ;
                endcase
            end
            // output register: loaded when a result finishes, cleared when taken
            if ((r_state == ST_FIN) && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_pt[0] <= i_start_x;
                        r_pt[1] <= i_start_y;
                        r_pt[2] <= i_first_ctrl_x;
                        r_pt[3] <= i_first_ctrl_y;
                        r_pt[4] <= i_second_ctrl_x;
                        r_pt[5] <= i_second_ctrl_y;
                        r_pt[6] <= i_end_x;
                        r_pt[7] <= i_end_y;
                        r_pt[8] <= i_query_x;
                        r_pt[9] <= i_query_y;
                        r_t     <= i_initial_param;
                        r_ld    <= '0;
                        r_cnt   <= '0;
                        r_conv  <= 1'b0;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_ld <= r_ld + 5'd1;
                    if (r_ld == LOAD_LAST) r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_pc <= '0;
                    if ((r_cnt < r_limit) && !r_conv) r_state <= ST_RD;
                    else r_state <= ST_FIN;
                end
                ST_RD: r_state <= ST_EX;
                ST_EX: begin
                    if (cur.op == OP_MUL) begin
                        r_state <= ST_MW;
                    end else begin
                        if (cur.dst == SL_G) r_g <= add_res;
                        if (cur.dst == SL_H) r_h <= add_res;
                        r_pc    <= r_pc + 6'd1;
                        r_state <= (r_pc == UOP_LAST) ? ST_STEP : ST_RD;
                    end
                end
                ST_MW: begin
                    if (mul_done) begin
                        r_pc    <= r_pc + 6'd1;
                        r_state <= (r_pc == UOP_LAST) ? ST_STEP : ST_RD;
                    end
                end
                ST_STEP: begin
                    if (h_pos) begin
                        r_state <= ST_DW;
                    end else begin
                        // gradient step when the curvature term is not positive
                        r_delta <= -r_g;
                        r_state <= ST_UPD;
                    end
                end
                ST_DW: begin
                    if (div_done) begin
                        r_delta <= r_g[63] ? $signed(div_q) : -$signed(div_q);
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_t     <= t_new;
                    r_cnt   <= r_cnt + ITER_W'(1);
                    r_conv  <= g_mag <= 64'(r_tol);
                    r_state <= ST_CHECK;
                end
                ST_FIN: begin
                    if (!r_ov || !i_stall) begin
                        r_o_param <= r_t;
                        r_o_iter  <= r_cnt;
                        r_o_conv  <= r_conv;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall           = (r_state != ST_IDLE);
    assign o_valid           = r_ov;
    assign o_projected_param = r_o_param;
    assign o_iterations_used = r_o_iter;
    assign o_converged       = r_o_conv;
    assign o_cfg_ready       = 1'b1;

    // a fresh result never reports more steps than the limit allows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !$past(r_ov)) |-> (o_iterations_used <= r_limit))
        else $error("iteration count above limit");

    // convergence needs at least one step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(o_converged && (o_iterations_used == '0)))
        else $error("converged with no step");

    // an update only happens inside the allowed number of steps
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_cnt < r_limit))
        else $error("step beyond iteration limit");

    // the divider only runs on a positive curvature term
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (!r_h[63] && (r_h != '0)))
        else $error("divider started on non-positive h");

endmodule

### rtl/bpp_mul.sv
module bpp_mul
    import bpp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  logic               i_shift,
    output logic               o_done,
    output logic signed [63:0] o_p
);

    logic [63:0]  r_x;
    logic [63:0]  r_y;
    logic         r_neg;
    logic         r_sh;
    logic [127:0] r_acc;
    logic [2:0]   r_step;
    logic         r_busy;
    logic         r_done;
    logic signed [63:0] r_p;

    logic [31:0]  xs;
    logic [31:0]  ys;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] shifted;
    logic [63:0]  lo;

    // one 32x32 partial product per cycle
    always_comb begin
        xs = r_step[1] ? r_x[63:32] : r_x[31:0];
        ys = r_step[0] ? r_y[63:32] : r_y[31:0];
        pp = 64'(xs) * 64'(ys);
        pp_sh = {64'b0, pp} << (7'd32 * (7'(r_step[1]) + 7'(r_step[0])));
        shifted = r_sh ? (r_acc >> PF) : r_acc;
        lo = (|shifted[127:63]) ? SAT_MAX : shifted[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_a[63] ? 64'(-i_a) : i_a;
                r_y    <= i_b[63] ? 64'(-i_b) : i_b;
                r_neg  <= i_a[63] ^ i_b[63];
                r_sh   <= i_shift;
                r_acc  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_p    <= r_neg ? -$signed(lo) : $signed(lo);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_acc  <= r_acc + pp_sh;
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

### rtl/bpp_div.sv
module bpp_div
    import bpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    localparam int NB = 64 + PF;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_n;
    logic [NB-1:0] r_q;
    logic [64:0]   r_r;
    logic [63:0]   r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [63:0]   r_quot;

    logic [64:0] rs;
    logic        fit;

    // restoring, one quotient bit per cycle
    always_comb begin
        rs  = {r_r[63:0], r_n[NB-1]};
        fit = rs >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= {i_num, {PF{1'b0}}};
                r_q    <= '0;
                r_r    <= '0;
                r_d    <= i_den;
                r_cnt  <= CW'(NB);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_r   <= fit ? rs - {1'b0, r_d} : rs;
                    r_q   <= {r_q[NB-2:0], fit};
                    r_n   <= r_n << 1;
                    r_cnt <= r_cnt - CW'(1);
                end else begin
                    r_quot <= (|r_q[NB-1:63]) ? SAT_MAX : {1'b0, r_q[62:0]};
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
